FILE: hdl/usbmsx_pkg.sv
package usbmsx_pkg;

    localparam logic [3:0] CODE_EMPTY      = 4'h0;
    localparam logic [3:0] CODE_START_CONT = 4'h4;
    localparam logic [7:0] SX_BEGIN        = 8'hF0;
    localparam logic [7:0] SX_FINISH       = 8'hF7;
    localparam logic [7:0] PAD_BYTE        = 8'h00;

    localparam int HELD_DEPTH = 6;
    localparam logic [2:0] START_LEN = 3'd5;
    localparam logic [2:0] CONT_LEN  = 3'd6;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef logic [HELD_DEPTH-1:0][7:0] t_bytes6;

    typedef struct packed {
        logic [3:0] code_a;
        logic [7:0] byte_a0;
        logic [7:0] byte_a1;
        logic [7:0] byte_a2;
        logic [3:0] code_b;
        logic [7:0] byte_b0;
        logic [7:0] byte_b1;
        logic [7:0] byte_b2;
        logic       end_packet;
        logic       short_error;
    } t_result;

    // packets produced by one transaction, first always used when num is non-zero
    typedef struct packed {
        logic [1:0] num;
        t_result    first;
        t_result    second;
    } t_push;

    // closing packet: n held bytes, then F7, then zero padding
    function automatic t_result make_end(t_bytes6 seq, logic [2:0] n);
        t_result    r;
        t_bytes6    e;
        logic [2:0] total;
        r     = '0;
        total = n + 3'd1;
        for (int i = 0; i < HELD_DEPTH; i++) begin
            if (3'(i) < n) begin
                e[i] = seq[i];
            end else if (3'(i) == n) begin
                e[i] = SX_FINISH;
            end else begin
                e[i] = PAD_BYTE;
            end
        end
        r.byte_a0 = e[0];
        r.byte_a1 = e[1];
        r.byte_a2 = e[2];
        r.byte_b0 = e[3];
        r.byte_b1 = e[4];
        r.byte_b2 = e[5];
        if (total > 3'd3) begin
            r.code_a = CODE_START_CONT;
            r.code_b = {1'b0, total} + 4'd1;
        end else begin
            r.code_a = CODE_START_CONT + {1'b0, total};
            r.code_b = CODE_EMPTY;
        end
        r.end_packet  = 1'b1;
        r.short_error = 1'b0;
        return r;
    endfunction

endpackage

FILE: hdl/usbmsx_packer.sv
module usbmsx_packer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output usbmsx_pkg::t_push  o_push
);

    logic                    r_started, n_started;
    logic [2:0]              r_count, n_count;
    usbmsx_pkg::t_bytes6     r_held;
    usbmsx_pkg::t_bytes6     seq;
    logic [2:0]              c1;

    // held bytes with the incoming byte dropped into its slot
    always_comb begin
        for (int k = 0; k < usbmsx_pkg::HELD_DEPTH; k++) begin
            seq[k] = (3'(k) == r_count) ? i_data_byte : r_held[k];
        end
    end

    assign c1 = r_count + 3'd1;

    always_comb begin
        n_started = r_started;
        n_count   = r_count;
        o_push    = '0;
        if (i_fire) begin
            if (!r_started) begin
                if (c1 == usbmsx_pkg::START_LEN) begin
                    o_push.first.code_a  = usbmsx_pkg::CODE_START_CONT;
                    o_push.first.byte_a0 = usbmsx_pkg::SX_BEGIN;
                    o_push.first.byte_a1 = seq[0];
                    o_push.first.byte_a2 = seq[1];
                    o_push.first.code_b  = usbmsx_pkg::CODE_START_CONT;
                    o_push.first.byte_b0 = seq[2];
                    o_push.first.byte_b1 = seq[3];
                    o_push.first.byte_b2 = seq[4];
                    o_push.num = 2'd1;
                    n_started  = 1'b1;
                    n_count    = 3'd0;
                    if (i_last_byte) begin
                        o_push.second = usbmsx_pkg::make_end(seq, 3'd0);
                        o_push.num    = 2'd2;
                        n_started     = 1'b0;
                    end
                end else if (i_last_byte) begin
                    o_push.first.short_error = 1'b1;
                    o_push.num = 2'd1;
                    n_started  = 1'b0;
                    n_count    = 3'd0;
                end else begin
                    n_count = c1;
                end
            end else begin
                if (c1 == usbmsx_pkg::CONT_LEN) begin
                    o_push.first.code_a  = usbmsx_pkg::CODE_START_CONT;
                    o_push.first.byte_a0 = seq[0];
                    o_push.first.byte_a1 = seq[1];
                    o_push.first.byte_a2 = seq[2];
                    o_push.first.code_b  = usbmsx_pkg::CODE_START_CONT;
                    o_push.first.byte_b0 = seq[3];
                    o_push.first.byte_b1 = seq[4];
                    o_push.first.byte_b2 = seq[5];
                    o_push.num = 2'd1;
                    n_count    = 3'd0;
                    if (i_last_byte) begin
                        o_push.second = usbmsx_pkg::make_end(seq, 3'd0);
                        o_push.num    = 2'd2;
                        n_started     = 1'b0;
                    end
                end else if (i_last_byte) begin
                    o_push.first = usbmsx_pkg::make_end(seq, c1);
                    o_push.num   = 2'd1;
                    n_started    = 1'b0;
                    n_count      = 3'd0;
                end else begin
                    n_count = c1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_count   <= 3'd0;
        end else begin
            r_started <= n_started;
            r_count   <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_held[r_count] <= i_data_byte;
        end
    end

endmodule

FILE: hdl/usbmsx_out_fifo.sv
module usbmsx_out_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  usbmsx_pkg::t_push   i_push,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_stall,
    output usbmsx_pkg::t_result o_res
);

    usbmsx_pkg::t_result                   r_mem [usbmsx_pkg::FIFO_DEPTH];
    logic [usbmsx_pkg::FIFO_AW-1:0]        r_wr_ptr, r_rd_ptr;
    logic [usbmsx_pkg::FIFO_CW-1:0]        r_count;
    logic [usbmsx_pkg::FIFO_AW-1:0]        wr_ptr_1;
    logic                                  pop;

    assign wr_ptr_1 = r_wr_ptr + 1'b1;
    assign o_valid  = (r_count != '0);
    assign pop      = o_valid && !i_stall;
    assign o_res    = r_mem[r_rd_ptr];
    // room for two packets must be there before a transaction is taken
    assign o_full   = (r_count > usbmsx_pkg::FIFO_CW'(usbmsx_pkg::FIFO_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + usbmsx_pkg::FIFO_AW'(i_push.num);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + usbmsx_pkg::FIFO_CW'(i_push.num)
                       - usbmsx_pkg::FIFO_CW'(pop);
        end
    end

endmodule

FILE: hdl/usb_midi_sysex_packetizer.sv
// each packet is registered in the result queue before it appears on the output
// throughput: one payload byte per cycle while o_stall is low; a closing byte may yield two packets, which the
//   four-entry result queue drains one per cycle while i_stall is low and new bytes keep flowing
// o_stall rises only while the result queue holds more than two packets
// reset (synchronous, active low) empties the queue and returns to waiting for a start packet
module usb_midi_sysex_packetizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    // packet channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_code_a,
    output logic [7:0] o_byte_a0,
    output logic [7:0] o_byte_a1,
    output logic [7:0] o_byte_a2,
    output logic [3:0] o_code_b,
    output logic [7:0] o_byte_b0,
    output logic [7:0] o_byte_b1,
    output logic [7:0] o_byte_b2,
    output logic       o_end_packet,
    output logic       o_short_error
);

    // a byte transaction completes when the queue has room for two packets
    logic                fire;
    logic                full;
    usbmsx_pkg::t_push   push;
    usbmsx_pkg::t_result res;

    assign o_stall = full;
    assign fire    = i_valid && !full;

    // packing logic: held bytes plus the incoming one form start, continuation,
    // closing or short-message packets in a single pass
    usbmsx_packer u_packer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (push)
    );

    // registered result queue, deep enough to absorb the extra closing packet
    usbmsx_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (res)
    );

    // unpack the head packet onto the ports
    assign o_code_a      = res.code_a;
    assign o_byte_a0     = res.byte_a0;
    assign o_byte_a1     = res.byte_a1;
    assign o_byte_a2     = res.byte_a2;
    assign o_code_b      = res.code_b;
    assign o_byte_b0     = res.byte_b0;
    assign o_byte_b1     = res.byte_b1;
    assign o_byte_b2     = res.byte_b2;
    assign o_end_packet  = res.end_packet;
    assign o_short_error = res.short_error;

endmodule

FILE: hdl/usbmsx_checker.sv
module usbmsx_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [3:0] o_code_a,
    input logic [3:0] o_code_b,
    input logic [7:0] o_byte_a0,
    input logic       o_end_packet,
    input logic       o_short_error
);

    // a packet is never both a closing packet and an error report
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_end_packet && o_short_error))
        else $error("end and error flags both set");

    // error reports carry no event
    a_error_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_short_error) |-> (o_code_a == usbmsx_pkg::CODE_EMPTY
            && o_code_b == usbmsx_pkg::CODE_EMPTY))
        else $error("error report with non-zero codes");

    // start and continuation packets have code 4 in both halves
    a_plain_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_short_error && !o_end_packet)
            |-> (o_code_a == usbmsx_pkg::CODE_START_CONT
                && o_code_b == usbmsx_pkg::CODE_START_CONT))
        else $error("ordinary packet with wrong codes");

    // closing packet first half code lies in 4..7
    a_end_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_end_packet) |-> (o_code_a >= usbmsx_pkg::CODE_START_CONT
            && o_code_a <= usbmsx_pkg::CODE_START_CONT + 4'd3))
        else $error("closing packet with bad first code");

    // a stalled packet stays on the port with its first code and first byte unchanged
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_code_a) && $stable(o_byte_a0)))
        else $error("stalled packet changed");

endmodule

bind usb_midi_sysex_packetizer usbmsx_checker u_usbmsx_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_code_a      (o_code_a),
    .o_code_b      (o_code_b),
    .o_byte_a0     (o_byte_a0),
    .o_end_packet  (o_end_packet),
    .o_short_error (o_short_error)
);
